>>> rtl/btc_pkg.sv
package btc_pkg;

  // result status codes
  localparam logic [1:0] StsOk   = 2'd0;
  localparam logic [1:0] StsBad  = 2'd1;
  localparam logic [1:0] StsZero = 2'd2;

  // configuration register indexes
  localparam logic [1:0] RegCalibTemp   = 2'd0;
  localparam logic [1:0] RegCalibPressA = 2'd1;
  localparam logic [1:0] RegCalibPressB = 2'd2;
  localparam logic [1:0] RegCalibP9     = 2'd3;

  // pipeline shape
  localparam int unsigned NumPre  = 12;
  localparam int unsigned NumDiv  = 32;
  localparam int unsigned NumPost = 3;
  localparam int unsigned NumStg  = NumPre + NumDiv + NumPost;

  // one pipeline stage; the word fields change meaning along the pipe
  typedef struct packed {
    logic        vld;
    logic        bad;
    logic        zero;
    logic        post;
    logic [1:0]  sts;
    logic [19:0] adcp;
    logic [31:0] tmp;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } stage_t;

  // arithmetic right shift of a 32-bit word
  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    asr = 32'($signed(x) >>> n);
  endfunction

  // sign extension of a 16-bit coefficient
  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage

>>> rtl/baro_temp_compensation.sv
// channel   dir  width  content
// s_axis    in   48     raw_pressure [23:0], raw_temperature [47:24]
// m_axis    out  72     status [1:0], temperature_centi [33:2], pressure_pa [65:34]
// cfg       in   64     register write, index 0..3
//
// 47 register stages: 11 for temperature and divisor, one divide set-up stage,
// 32 stages of a restoring divider (one quotient bit each), 3 for the final
// pressure correction. One readout per cycle while the output is not stalled.
// Reset clears the calibration registers and all valid bits.
// A stalled output holds the whole pipe; nothing is dropped or repeated.
module baro_temp_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // raw_pressure, raw_temperature
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // status, temperature_centi, pressure_pa, zero pad
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  localparam int unsigned NS = btc_pkg::NumStg;
  localparam int unsigned D0 = btc_pkg::NumPre;
  localparam int unsigned P0 = btc_pkg::NumPre + btc_pkg::NumDiv;

  logic [47:0] calib_temp_q;
  logic [63:0] calib_pa_q;
  logic [63:0] calib_pb_q;
  logic [15:0] calib_p9_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_temp_q <= '0;
      calib_pa_q   <= '0;
      calib_pb_q   <= '0;
      calib_p9_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        btc_pkg::RegCalibTemp:   calib_temp_q <= cfg_wdata_i[47:0];
        btc_pkg::RegCalibPressA: calib_pa_q   <= cfg_wdata_i;
        btc_pkg::RegCalibPressB: calib_pb_q   <= cfg_wdata_i;
        btc_pkg::RegCalibP9:     calib_p9_q   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // coefficients
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, calib_temp_q[15:0]};
  assign t2 = btc_pkg::sx16(calib_temp_q[31:16]);
  assign t3 = btc_pkg::sx16(calib_temp_q[47:32]);
  assign p1 = {16'd0, calib_pa_q[15:0]};
  assign p2 = btc_pkg::sx16(calib_pa_q[31:16]);
  assign p3 = btc_pkg::sx16(calib_pa_q[47:32]);
  assign p4 = btc_pkg::sx16(calib_pa_q[63:48]);
  assign p5 = btc_pkg::sx16(calib_pb_q[15:0]);
  assign p6 = btc_pkg::sx16(calib_pb_q[31:16]);
  assign p7 = btc_pkg::sx16(calib_pb_q[47:32]);
  assign p8 = btc_pkg::sx16(calib_pb_q[63:48]);
  assign p9 = btc_pkg::sx16(calib_p9_q);

  btc_pkg::stage_t st_q [NS];
  btc_pkg::stage_t st_d [NS];

  logic adv;
  assign adv           = !st_q[NS-1].vld || m_axis_tready;
  assign s_axis_tready = adv;

  logic [31:0] h;
  logic [32:0] trial [btc_pkg::NumDiv];
  logic        ge    [btc_pkg::NumDiv];
  logic [31:0] pcorr;

  // stage logic
  always_comb begin
    for (int k = 1; k < NS; k++) begin
      st_d[k] = st_q[k-1];
    end

    // capture: nibble check and unpack
    st_d[0]      = '0;
    st_d[0].vld  = s_axis_tvalid;
    st_d[0].bad  = (s_axis_tdata[3:0] != 4'd0) || (s_axis_tdata[27:24] != 4'd0);
    st_d[0].adcp = s_axis_tdata[23:4];
    st_d[0].a    = {12'd0, s_axis_tdata[47:28]};

    // temperature products
    st_d[1].a = ((st_q[0].a >> 3) - (t1 << 1)) * t2;
    st_d[1].b = ((st_q[0].a >> 4) - t1) * ((st_q[0].a >> 4) - t1);
    st_d[2].a = btc_pkg::asr(st_q[1].a, 5'd11);
    st_d[2].b = btc_pkg::asr(st_q[1].b, 5'd12) * t3;
    // t_fine
    st_d[3].a = st_q[2].a + btc_pkg::asr(st_q[2].b, 5'd14);
    // temperature and first pressure term
    st_d[4].tmp = btc_pkg::asr(st_q[3].a * 32'd5 + 32'd128, 5'd8);
    st_d[4].a   = btc_pkg::asr(st_q[3].a, 5'd1) - 32'd64000;
    // squares and linear terms
    h         = btc_pkg::asr(st_q[4].a, 5'd2);
    st_d[5].b = h * h;
    st_d[5].c = st_q[4].a * p5;
    st_d[5].d = p2 * st_q[4].a;
    st_d[6].a = btc_pkg::asr(st_q[5].b, 5'd11) * p6;
    st_d[6].b = p3 * btc_pkg::asr(st_q[5].b, 5'd13);
    st_d[7].a = st_q[6].a + (st_q[6].c << 1);
    st_d[7].b = btc_pkg::asr(st_q[6].b, 5'd3) + btc_pkg::asr(st_q[6].d, 5'd1);
    st_d[8].a = btc_pkg::asr(st_q[7].a, 5'd2) + (p4 << 16);
    st_d[8].b = 32'd32768 + btc_pkg::asr(st_q[7].b, 5'd18);
    // divisor
    st_d[9].b = btc_pkg::asr(st_q[8].b * p1, 5'd15);
    // dividend before scaling
    st_d[10].a    = ((32'd1048576 - {12'd0, st_q[9].adcp})
                    - btc_pkg::asr(st_q[9].a, 5'd12)) * 32'd3125;
    st_d[10].zero = (st_q[9].b == 32'd0);
    // divide set-up
    st_d[11].post = st_q[10].a[31];
    st_d[11].a    = st_q[10].a[31] ? st_q[10].a : (st_q[10].a << 1);
    st_d[11].c    = '0;

    // restoring divider, one quotient bit per stage
    for (int j = 0; j < btc_pkg::NumDiv; j++) begin
      trial[j] = {st_q[D0+j-1].c, st_q[D0+j-1].a[31]};
      ge[j]    = trial[j] >= {1'b0, st_q[D0+j-1].b};
      st_d[D0+j].c = ge[j] ? 32'(trial[j] - {1'b0, st_q[D0+j-1].b}) : trial[j][31:0];
      st_d[D0+j].a = {st_q[D0+j-1].a[30:0], ge[j]};
    end

    // final correction products
    st_d[P0].a = st_q[P0-1].post ? (st_q[P0-1].a << 1) : st_q[P0-1].a;
    st_d[P0].b = ((st_d[P0].a >> 3) * (st_d[P0].a >> 3)) >> 13;
    st_d[P0].c = (st_d[P0].a >> 2) * p8;
    st_d[P0+1].b = btc_pkg::asr(p9 * st_q[P0].b, 5'd12);
    st_d[P0+1].c = btc_pkg::asr(st_q[P0].c, 5'd13);
    // result
    pcorr = st_q[P0+1].a
          + btc_pkg::asr(st_q[P0+1].b + st_q[P0+1].c + p7, 5'd4);
    if (st_q[P0+1].bad) begin
      st_d[P0+2].sts = btc_pkg::StsBad;
      st_d[P0+2].tmp = '0;
      st_d[P0+2].a   = '0;
    end else if (st_q[P0+1].zero) begin
      st_d[P0+2].sts = btc_pkg::StsZero;
      st_d[P0+2].a   = '0;
    end else begin
      st_d[P0+2].sts = btc_pkg::StsOk;
      st_d[P0+2].a   = pcorr;
    end
  end

  // pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) begin
        st_q[k] <= '0;
      end
    end else if (adv) begin
      for (int k = 0; k < NS; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // output
  assign m_axis_tvalid = st_q[NS-1].vld;
  assign m_axis_tdata  = {6'd0, st_q[NS-1].a, st_q[NS-1].tmp, st_q[NS-1].sts};

endmodule
